/* hw/rtl/bpvs_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bpvs_pkg: shared types and constants for the bit packed vector store
// Field widths, request and status codes, controller states, and the
// command/status bundles between controller and datapath.
// ============================================================================
package bpvs_pkg;

	// storage geometry
	localparam int unsigned NUM_WORDS = 1024;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned LEN_MAX   = 131071;
	localparam int unsigned CAP_BITS  =
		(NUM_WORDS * WORD_W > LEN_MAX) ? LEN_MAX : NUM_WORDS * WORD_W;
	localparam int unsigned MAX_WORDS = (CAP_BITS + WORD_W - 1) / WORD_W;
	localparam int unsigned AW        = $clog2(NUM_WORDS);
	localparam int unsigned IU_W      = $clog2(MAX_WORDS + 1);

	// field widths
	localparam int unsigned REQ_W  = 3;
	localparam int unsigned POS_W  = 16;
	localparam int unsigned LEN_W  = 17;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned FCNT_W = 7;
	localparam int unsigned OFF_W  = 6;
	localparam int unsigned EXT_W  = LEN_W + 1;
	localparam int unsigned IDX_W  = EXT_W - OFF_W;
	localparam int unsigned MAX_FIELD = 64;

	typedef logic [AW-1:0]     addr_t;
	typedef logic [IU_W-1:0]   iu_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [EXT_W-1:0]  ext_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 3'd0,
		REQ_RESIZE = 3'd1,
		REQ_PUSH   = 3'd2,
		REQ_POP    = 3'd3,
		REQ_WRITE  = 3'd4,
		REQ_READ   = 3'd5
	} req_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_OVER  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_DONE,
		KIND_FILL,
		KIND_ACCESS
	} dec_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FILL,
		S_RD0,
		S_RD1,
		S_RD2,
		S_WR0,
		S_WR1,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [POS_W-1:0]  bit_position;
		logic [LEN_W-1:0]  bit_count;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [LEN_W-1:0]  length;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic fill;
		logic rd_w0;
		logic rd_w1;
		logic cap_w0;
		logic cap_w1;
		logic wr_w0;
		logic wr_w1;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		dec_kind_t kind;
		logic      straddle;
		logic      is_read;
		logic      fill_last;
	} dp_status_t;

endpackage

/* hw/rtl/bpvs_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// bpvs_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ============================================================================
module bpvs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/bpvs_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// bpvs_datapath: request decode, length, word store and field merge
// Holds the request and bit length, classifies each request, reads and
// writes the word RAM one word per cycle, and builds the result.
// ============================================================================
module bpvs_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpvs_pkg::req_t       req,
	input  bpvs_pkg::dp_cmd_t    cmd,
	output bpvs_pkg::dp_status_t st,
	output bpvs_pkg::rsp_t       rsp
);

	bpvs_pkg::req_t    req_q;
	bpvs_pkg::len_t    len_q;
	bpvs_pkg::len_t    acc_pos_q;
	logic [bpvs_pkg::FCNT_W-1:0] acc_cnt_q;
	logic              acc_read_q;
	bpvs_pkg::iu_t     iu_old_q;
	bpvs_pkg::iu_t     fill_ptr_q;
	bpvs_pkg::iu_t     fill_end_q;
	bpvs_pkg::status_t stat_q;
	bpvs_pkg::word_t   word0_q;
	bpvs_pkg::word_t   word1_q;
	bpvs_pkg::rsp_t    rsp_q;

	// decode
	bpvs_pkg::ext_t      iu_cur_sum;
	bpvs_pkg::ext_t      iu_cnt_sum;
	bpvs_pkg::iu_t       iu_cur;
	bpvs_pkg::iu_t       iu_cnt;
	bpvs_pkg::ext_t      push_sum;
	bpvs_pkg::ext_t      last_sum;
	bpvs_pkg::ext_t      last_word;
	logic                cnt_over;
	logic                cnt_zero;
	bpvs_pkg::dec_kind_t dec_kind;
	bpvs_pkg::status_t   dec_status;
	logic                dec_len_we;
	bpvs_pkg::len_t      dec_len;
	bpvs_pkg::len_t      dec_pos;
	logic                dec_read;

	// access
	logic [bpvs_pkg::OFF_W-1:0] off;
	bpvs_pkg::idx_t  w0_idx;
	bpvs_pkg::idx_t  w1_idx;
	bpvs_pkg::ext_t  acc_last;
	bpvs_pkg::word_t fmask;
	logic [2*bpvs_pkg::WORD_W-1:0] pair;
	logic [2*bpvs_pkg::WORD_W-1:0] pair_shr;
	logic [2*bpvs_pkg::WORD_W-1:0] mask_shl;
	logic [2*bpvs_pkg::WORD_W-1:0] bits_shl;
	logic [2*bpvs_pkg::WORD_W-1:0] merged;
	bpvs_pkg::word_t field_rd;

	// RAM port
	logic            ram_we;
	bpvs_pkg::addr_t ram_waddr;
	bpvs_pkg::word_t ram_wdata;
	logic            ram_re;
	bpvs_pkg::addr_t ram_raddr;
	bpvs_pkg::word_t ram_rdata;

	assign iu_cur_sum = {1'b0, len_q} + bpvs_pkg::ext_t'(bpvs_pkg::WORD_W - 1);
	assign iu_cnt_sum = {1'b0, req_q.bit_count} + bpvs_pkg::ext_t'(bpvs_pkg::WORD_W - 1);
	assign iu_cur     = bpvs_pkg::iu_t'(iu_cur_sum >> bpvs_pkg::OFF_W);
	assign iu_cnt     = bpvs_pkg::iu_t'(iu_cnt_sum >> bpvs_pkg::OFF_W);
	assign push_sum   = {1'b0, len_q} + {1'b0, req_q.bit_count};
	assign last_sum   = bpvs_pkg::ext_t'(req_q.bit_position) + {1'b0, req_q.bit_count}
		- bpvs_pkg::ext_t'(1);
	assign last_word  = last_sum >> bpvs_pkg::OFF_W;
	assign cnt_over   = req_q.bit_count > bpvs_pkg::len_t'(bpvs_pkg::MAX_FIELD);
	assign cnt_zero   = req_q.bit_count == '0;

	always_comb begin
		dec_kind   = bpvs_pkg::KIND_DONE;
		dec_status = bpvs_pkg::ST_DONE;
		dec_len_we = 1'b0;
		dec_len    = len_q;
		dec_pos    = len_q;
		dec_read   = 1'b0;
		unique case (req_q.req_type)
			bpvs_pkg::REQ_CLEAR: begin
				dec_len_we = 1'b1;
				dec_len    = '0;
			end
			bpvs_pkg::REQ_RESIZE: begin
				if (req_q.bit_count > bpvs_pkg::len_t'(bpvs_pkg::CAP_BITS)) begin
					dec_status = bpvs_pkg::ST_RANGE;
				end else begin
					dec_len_we = 1'b1;
					dec_len    = req_q.bit_count;
					// new words come into use: zero them first
					if (iu_cnt > iu_cur) begin
						dec_kind = bpvs_pkg::KIND_FILL;
					end
				end
			end
			bpvs_pkg::REQ_PUSH: begin
				priority if (cnt_over) begin
					dec_status = bpvs_pkg::ST_OVER;
				end else if (cnt_zero) begin
					dec_status = bpvs_pkg::ST_DONE;
				end else if (push_sum > bpvs_pkg::ext_t'(bpvs_pkg::CAP_BITS)) begin
					dec_status = bpvs_pkg::ST_RANGE;
				end else begin
					dec_len_we = 1'b1;
					dec_len    = bpvs_pkg::len_t'(push_sum);
					dec_kind   = bpvs_pkg::KIND_ACCESS;
				end
			end
			bpvs_pkg::REQ_POP: begin
				dec_len_we = 1'b1;
				dec_len    = (req_q.bit_count >= len_q) ? '0 : len_q - req_q.bit_count;
			end
			bpvs_pkg::REQ_WRITE, bpvs_pkg::REQ_READ: begin
				priority if (cnt_over) begin
					dec_status = bpvs_pkg::ST_OVER;
				end else if (cnt_zero) begin
					dec_status = bpvs_pkg::ST_DONE;
				end else if (last_word >= bpvs_pkg::ext_t'(iu_cur)) begin
					dec_status = bpvs_pkg::ST_RANGE;
				end else begin
					dec_kind = bpvs_pkg::KIND_ACCESS;
					dec_pos  = bpvs_pkg::len_t'(req_q.bit_position);
					dec_read = req_q.req_type == bpvs_pkg::REQ_READ;
				end
			end
			default: begin
			end
		endcase
	end

	// field geometry of the pending access
	assign off      = acc_pos_q[bpvs_pkg::OFF_W-1:0];
	assign w0_idx   = bpvs_pkg::idx_t'(acc_pos_q >> bpvs_pkg::OFF_W);
	assign acc_last = {1'b0, acc_pos_q} + bpvs_pkg::ext_t'(acc_cnt_q) - bpvs_pkg::ext_t'(1);
	assign w1_idx   = bpvs_pkg::idx_t'(acc_last >> bpvs_pkg::OFF_W);
	assign fmask    = acc_cnt_q[bpvs_pkg::FCNT_W-1] ? '1
		: ((bpvs_pkg::word_t'(1) << acc_cnt_q[bpvs_pkg::OFF_W-1:0]) - bpvs_pkg::word_t'(1));

	assign pair     = {word1_q, word0_q};
	assign pair_shr = pair >> off;
	assign field_rd = pair_shr[bpvs_pkg::WORD_W-1:0] & fmask;
	assign mask_shl = {{bpvs_pkg::WORD_W{1'b0}}, fmask} << off;
	assign bits_shl = {{bpvs_pkg::WORD_W{1'b0}}, req_q.value & fmask} << off;
	assign merged   = (pair & ~mask_shl) | bits_shl;

	// one RAM write per cycle: zero fill, low word or high word
	assign ram_we    = cmd.fill | cmd.wr_w0 | cmd.wr_w1;
	assign ram_re    = cmd.rd_w0 | cmd.rd_w1;
	assign ram_raddr = cmd.rd_w1 ? bpvs_pkg::addr_t'(w1_idx) : bpvs_pkg::addr_t'(w0_idx);

	always_comb begin
		priority if (cmd.fill) begin
			ram_waddr = bpvs_pkg::addr_t'(fill_ptr_q);
			ram_wdata = '0;
		end else if (cmd.wr_w1) begin
			ram_waddr = bpvs_pkg::addr_t'(w1_idx);
			ram_wdata = merged[2*bpvs_pkg::WORD_W-1:bpvs_pkg::WORD_W];
		end else begin
			ram_waddr = bpvs_pkg::addr_t'(w0_idx);
			ram_wdata = merged[bpvs_pkg::WORD_W-1:0];
		end
	end

	bpvs_ram #(
		.WIDTH(bpvs_pkg::WORD_W),
		.DEPTH(bpvs_pkg::NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.decode && dec_len_we) begin
			len_q <= dec_len;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.decode) begin
			stat_q     <= dec_status;
			acc_pos_q  <= dec_pos;
			acc_cnt_q  <= req_q.bit_count[bpvs_pkg::FCNT_W-1:0];
			acc_read_q <= dec_read;
			iu_old_q   <= iu_cur;
			fill_end_q <= iu_cnt;
		end
		if (cmd.decode) begin
			fill_ptr_q <= iu_cur;
		end else if (cmd.fill) begin
			fill_ptr_q <= fill_ptr_q + bpvs_pkg::iu_t'(1);
		end
		// words past the old use count have no valid contents: read as zero
		if (cmd.cap_w0) begin
			word0_q <= (bpvs_pkg::ext_t'(w0_idx) >= bpvs_pkg::ext_t'(iu_old_q)) ? '0 : ram_rdata;
		end
		if (cmd.cap_w1) begin
			word1_q <= (bpvs_pkg::ext_t'(w1_idx) >= bpvs_pkg::ext_t'(iu_old_q)) ? '0 : ram_rdata;
		end
		if (cmd.load) begin
			rsp_q.read_data <= acc_read_q ? field_rd : '0;
			rsp_q.length    <= len_q;
			rsp_q.status    <= stat_q;
		end
	end

	assign st.kind      = dec_kind;
	assign st.straddle  = w1_idx != w0_idx;
	assign st.is_read   = acc_read_q;
	assign st.fill_last = (fill_ptr_q + bpvs_pkg::iu_t'(1)) == fill_end_q;

	assign rsp = rsp_q;

endmodule

/* hw/rtl/bpvs_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// bpvs_ctrl: request sequencer
// Steps each request through decode, zero fill or word read and write,
// and hands the result to the output register.
// ============================================================================
module bpvs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  bpvs_pkg::dp_status_t st,
	output bpvs_pkg::dp_cmd_t    cmd
);

	bpvs_pkg::state_t state_q;
	bpvs_pkg::state_t state_d;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpvs_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = bpvs_pkg::S_DECODE;
				end
			end
			bpvs_pkg::S_DECODE: begin
				unique case (st.kind)
					bpvs_pkg::KIND_FILL:   state_d = bpvs_pkg::S_FILL;
					bpvs_pkg::KIND_ACCESS: state_d = bpvs_pkg::S_RD0;
					default:               state_d = bpvs_pkg::S_DONE;
				endcase
			end
			bpvs_pkg::S_FILL: begin
				if (st.fill_last) begin
					state_d = bpvs_pkg::S_DONE;
				end
			end
			bpvs_pkg::S_RD0: state_d = bpvs_pkg::S_RD1;
			bpvs_pkg::S_RD1: state_d = bpvs_pkg::S_RD2;
			bpvs_pkg::S_RD2: state_d = st.is_read ? bpvs_pkg::S_DONE : bpvs_pkg::S_WR0;
			bpvs_pkg::S_WR0: state_d = st.straddle ? bpvs_pkg::S_WR1 : bpvs_pkg::S_DONE;
			bpvs_pkg::S_WR1: state_d = bpvs_pkg::S_DONE;
			bpvs_pkg::S_DONE: begin
				if (slot_free) begin
					state_d = bpvs_pkg::S_IDLE;
				end
			end
			default: state_d = bpvs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			bpvs_pkg::S_IDLE:   cmd.latch  = req_valid;
			bpvs_pkg::S_DECODE: cmd.decode = 1'b1;
			bpvs_pkg::S_FILL:   cmd.fill   = 1'b1;
			bpvs_pkg::S_RD0:    cmd.rd_w0  = 1'b1;
			bpvs_pkg::S_RD1: begin
				cmd.cap_w0 = 1'b1;
				cmd.rd_w1  = 1'b1;
			end
			bpvs_pkg::S_RD2:    cmd.cap_w1 = 1'b1;
			bpvs_pkg::S_WR0:    cmd.wr_w0  = 1'b1;
			bpvs_pkg::S_WR1:    cmd.wr_w1  = 1'b1;
			bpvs_pkg::S_DONE:   cmd.load   = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpvs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the result until its transfer
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != bpvs_pkg::S_IDLE;
	assign rsp_valid = out_valid_q;

endmodule

/* hw/rtl/bit_packed_vector_store.sv */
`timescale 1ns / 1ps
// ============================================================================
// bit_packed_vector_store: bit addressable store of 64-bit words
// Clear, resize, push, pop, write and read of bit fields over a word RAM.
// ============================================================================
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | bpvs_pkg::req_t
//  rsp     | out       | rsp_valid, rsp_stall | bpvs_pkg::rsp_t
//
// One request at a time. Clear, pop, shrinking resize and rejected requests
// go from decode to the result; read fetches both field words; write and push
// also write back the low word, and the high word when the field straddles;
// a growing resize zeroes each word brought into use via the single write port.
// Reset leaves the store empty; no clearing pass is needed.
// A request can be taken while the previous result waits under rsp_stall.
// ============================================================================
module bit_packed_vector_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bpvs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bpvs_pkg::rsp_t rsp
);

	bpvs_pkg::dp_cmd_t    cmd;
	bpvs_pkg::dp_status_t st;

	bpvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bpvs_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.st    (st),
		.rsp   (rsp)
	);

	// a taken request keeps the input closed while it is worked on
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input open right after a transfer");

	// the RAM has one write port
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill, cmd.wr_w0, cmd.wr_w1}))
		else $error("two RAM writes in one cycle");

	// never overwrite a result that still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(rsp_valid && rsp_stall))
		else $error("pending result overwritten");

	// reported length stays within capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.length <= bpvs_pkg::len_t'(bpvs_pkg::CAP_BITS)))
		else $error("length beyond capacity");

endmodule

/* dv/tb_bit_packed_vector_store.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_bit_packed_vector_store: self-checking bench for the bit packed store
// Drives clear, resize, push, pop, write and read requests, first a directed
// set of corner cases and then random traffic shaped around the live length.
// An internal bit-accurate store model predicts every response, and the
// monitor compares each one field by field. Both sides idle at random.
// ============================================================================
module tb_bit_packed_vector_store;

	localparam int unsigned RANDOM_ITEMS   = 600;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned REQ_TOP        = (1 << bpvs_pkg::REQ_W) - 1;

	typedef logic [bpvs_pkg::REQ_W-1:0] code_t;
	typedef logic [bpvs_pkg::POS_W-1:0] pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	bpvs_pkg::req_t req_bus = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	bpvs_pkg::rsp_t rsp_bus;

	bpvs_pkg::req_t req_backlog[$];
	bpvs_pkg::rsp_t due_results[$];
	int unsigned errors = 0;
	int unsigned result_no = 0;
	int unsigned queued_no = 0;
	int unsigned quiet = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	// store model
	bpvs_pkg::word_t mem_words [bpvs_pkg::NUM_WORDS];
	bit mem_valid [bpvs_pkg::NUM_WORDS];
	int unsigned vec_len = 0;

	bit_packed_vector_store DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_bus),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_bus)
	);

	always #5 clk = ~clk;

	function automatic void enqueue_req(bpvs_pkg::req_t r);
		req_backlog = {req_backlog, r};
		queued_no++;
	endfunction

	function automatic int unsigned used_words(int unsigned len);
		return (len + bpvs_pkg::WORD_W - 1) / bpvs_pkg::WORD_W;
	endfunction

	function automatic bpvs_pkg::word_t load_word(int unsigned i);
		if (i >= bpvs_pkg::NUM_WORDS || !mem_valid[i])
			return '0;
		return mem_words[i];
	endfunction

	function automatic void store_word(int unsigned i, bpvs_pkg::word_t v);
		if (i < bpvs_pkg::NUM_WORDS) begin
			mem_words[i] = v;
			mem_valid[i] = 1'b1;
		end
	endfunction

	// words dropping out of use read back as zero
	function automatic void set_len(int unsigned len);
		vec_len = len;
		for (int unsigned i = used_words(len); i < bpvs_pkg::NUM_WORDS; i++)
			mem_valid[i] = 1'b0;
	endfunction

	function automatic bpvs_pkg::word_t field_mask(int unsigned n);
		if (n >= bpvs_pkg::WORD_W)
			return '1;
		return (bpvs_pkg::word_t'(1) << n) - bpvs_pkg::word_t'(1);
	endfunction

	function automatic void insert_bits(int unsigned pos, int unsigned n,
			bpvs_pkg::word_t v);
		int unsigned off, w0, w1;
		bpvs_pkg::word_t m, bits;
		off = pos % bpvs_pkg::WORD_W;
		w0 = pos / bpvs_pkg::WORD_W;
		w1 = (pos + n - 1) / bpvs_pkg::WORD_W;
		m = field_mask(n);
		bits = v & m;
		store_word(w0, (load_word(w0) & ~(m << off)) | (bits << off));
		if (w1 != w0)
			store_word(w1, (load_word(w1) & ~(m >> (bpvs_pkg::WORD_W - off))) |
				(bits >> (bpvs_pkg::WORD_W - off)));
	endfunction

	function automatic bpvs_pkg::word_t extract_bits(int unsigned pos, int unsigned n);
		int unsigned off, w0, w1;
		bpvs_pkg::word_t m, r;
		off = pos % bpvs_pkg::WORD_W;
		w0 = pos / bpvs_pkg::WORD_W;
		w1 = (pos + n - 1) / bpvs_pkg::WORD_W;
		m = field_mask(n);
		r = (load_word(w0) >> off) & m;
		if (w1 != w0)
			r |= (load_word(w1) << (bpvs_pkg::WORD_W - off)) & m;
		return r;
	endfunction

	function automatic bpvs_pkg::rsp_t apply_request(bpvs_pkg::req_t r);
		bpvs_pkg::rsp_t res;
		int unsigned pos, cnt;
		pos = r.bit_position;
		cnt = r.bit_count;
		res = '0;
		res.status = bpvs_pkg::ST_DONE;
		case (r.req_type)
			bpvs_pkg::REQ_CLEAR: set_len(0);
			bpvs_pkg::REQ_RESIZE: begin
				if (cnt > bpvs_pkg::CAP_BITS)
					res.status = bpvs_pkg::ST_RANGE;
				else
					set_len(cnt);
			end
			bpvs_pkg::REQ_PUSH: begin
				if (cnt > bpvs_pkg::MAX_FIELD)
					res.status = bpvs_pkg::ST_OVER;
				else if (cnt != 0) begin
					if (vec_len + cnt > bpvs_pkg::CAP_BITS)
						res.status = bpvs_pkg::ST_RANGE;
					else begin
						pos = vec_len;
						vec_len = vec_len + cnt;
						insert_bits(pos, cnt, r.value);
					end
				end
			end
			bpvs_pkg::REQ_POP: set_len((cnt >= vec_len) ? 0 : vec_len - cnt);
			bpvs_pkg::REQ_WRITE, bpvs_pkg::REQ_READ: begin
				if (cnt > bpvs_pkg::MAX_FIELD)
					res.status = bpvs_pkg::ST_OVER;
				else if (cnt != 0) begin
					if ((pos + cnt - 1) / bpvs_pkg::WORD_W >= used_words(vec_len))
						res.status = bpvs_pkg::ST_RANGE;
					else if (r.req_type == bpvs_pkg::REQ_WRITE)
						insert_bits(pos, cnt, r.value);
					else
						res.read_data = extract_bits(pos, cnt);
				end
			end
			default: ;
		endcase
		res.length = bpvs_pkg::len_t'(vec_len);
		return res;
	endfunction

	function automatic bpvs_pkg::req_t make_req(bpvs_pkg::req_code_t code,
			int unsigned pos, int unsigned cnt, bpvs_pkg::word_t v);
		bpvs_pkg::req_t r;
		r.req_type = code;
		r.bit_position = pos[bpvs_pkg::POS_W-1:0];
		r.bit_count = cnt[bpvs_pkg::LEN_W-1:0];
		r.value = v;
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// field counts: mostly legal, with zero, full and oversized ones mixed in
	function automatic int unsigned field_count();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 6)
			return 0;
		if (p < 12)
			return $urandom_range(bpvs_pkg::MAX_FIELD + 1, bpvs_pkg::LEN_MAX);
		if (p < 20)
			return bpvs_pkg::MAX_FIELD;
		return $urandom_range(1, bpvs_pkg::MAX_FIELD - 1);
	endfunction

	function automatic bpvs_pkg::req_t random_req();
		bpvs_pkg::req_t r;
		int unsigned p, q, span;
		r.req_type = bpvs_pkg::REQ_READ;
		r.bit_position = pos_t'($urandom);
		r.bit_count = '0;
		r.value = {$urandom, $urandom};
		span = used_words(vec_len) * bpvs_pkg::WORD_W;
		p = $urandom_range(0, 99);
		if (p < 4)
			r.req_type = bpvs_pkg::REQ_CLEAR;
		else if (p < 12) begin
			r.req_type = bpvs_pkg::REQ_RESIZE;
			q = $urandom_range(0, 29);
			if (q == 0)
				r.bit_count = bpvs_pkg::len_t'($urandom_range(bpvs_pkg::CAP_BITS + 1,
					bpvs_pkg::LEN_MAX));
			else if (q < 3)
				r.bit_count = bpvs_pkg::len_t'($urandom_range(0, bpvs_pkg::CAP_BITS));
			else
				r.bit_count = bpvs_pkg::len_t'($urandom_range(0, 1500));
		end else if (p < 36) begin
			r.req_type = bpvs_pkg::REQ_PUSH;
			r.bit_count = bpvs_pkg::len_t'(field_count());
		end else if (p < 46) begin
			r.req_type = bpvs_pkg::REQ_POP;
			if ($urandom_range(0, 19) == 0)
				r.bit_count = bpvs_pkg::len_t'($urandom);
			else
				r.bit_count = bpvs_pkg::len_t'($urandom_range(0, 100));
		end else if (p < 96) begin
			r.req_type = (p < 70) ? bpvs_pkg::REQ_WRITE : bpvs_pkg::REQ_READ;
			r.bit_count = bpvs_pkg::len_t'(field_count());
			// aim inside the words in use most of the time
			if (span != 0 && $urandom_range(0, 9) != 0)
				r.bit_position = pos_t'($urandom_range(0, span - 1));
		end else
			r.req_type = code_t'($urandom_range(int'(bpvs_pkg::REQ_READ) + 1, REQ_TOP));
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin : drive_req
		logic busy;
		busy = req_valid;
		if (!arst_n) begin
			busy = 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				due_results = {due_results, apply_request(req_bus)};
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap != 0)
					send_gap--;
				else if (req_backlog.size() != 0) begin
					req_bus <= req_backlog.pop_front();
					busy = 1'b1;
					if ($urandom_range(0, 49) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : idle_len();
				end
			end
		end
		req_valid <= busy;
	end

	// response monitor and stall generator
	always @(posedge clk) begin : watch_rsp
		bpvs_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				result_no++;
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("ERROR: result %0d arrived with none outstanding:",
							result_no, " data %h len %0d status %0d",
							rsp_bus.read_data, rsp_bus.length, rsp_bus.status);
				end else begin
					want = due_results.pop_front();
					if (rsp_bus.read_data !== want.read_data ||
							rsp_bus.length !== want.length ||
							rsp_bus.status !== want.status) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("ERROR: result %0d: expected data %h len %0d status %0d,",
								result_no, want.read_data, want.length, want.status,
								" got data %h len %0d status %0d",
								rsp_bus.read_data, rsp_bus.length, rsp_bus.status);
					end
				end
			end
			if ($urandom_range(0, 79) == 0)
				recv_calm = !recv_calm;
			if (stall_left != 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
				stall_left = idle_len();
				rsp_stall <= 1'b1;
			end else
				rsp_stall <= 1'b0;
		end
	end

	// end the run if nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin : stimulus
		bpvs_pkg::req_t r;
		int unsigned n;
		bpvs_pkg::word_t ones;
		ones = '1;

		// directed corner cases
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 0, 1, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_PUSH, 0, bpvs_pkg::MAX_FIELD, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_PUSH, 0, 5, 64'hF0F0_F0F0_F0F0_F0FF));
		enqueue_req(make_req(bpvs_pkg::REQ_PUSH, 0, 0, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_PUSH, 0, bpvs_pkg::MAX_FIELD + 1, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 60, 8, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_WRITE, 62, 4, 64'hFFFF_FFFF_FFFF_FFFA));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 0, bpvs_pkg::MAX_FIELD, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 64, bpvs_pkg::MAX_FIELD, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_WRITE, 3, 100, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 3, 0, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_POP, 0, 63, '0));
		// grown words come back as zero, the kept word keeps its tail bits
		enqueue_req(make_req(bpvs_pkg::REQ_RESIZE, 0, 256, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 0, bpvs_pkg::MAX_FIELD, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_READ, 130, bpvs_pkg::MAX_FIELD, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_RESIZE, 0, bpvs_pkg::CAP_BITS, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_WRITE, bpvs_pkg::CAP_BITS - 1, 1, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_READ,
			bpvs_pkg::CAP_BITS - bpvs_pkg::MAX_FIELD, bpvs_pkg::MAX_FIELD, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_WRITE, bpvs_pkg::CAP_BITS - 36,
			bpvs_pkg::MAX_FIELD, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_PUSH, 0, 1, ones));
		enqueue_req(make_req(bpvs_pkg::REQ_RESIZE, 0, bpvs_pkg::LEN_MAX, '0));
		enqueue_req(make_req(bpvs_pkg::REQ_POP, 0, 70000, '0));
		r = make_req(bpvs_pkg::REQ_CLEAR, 'hFFFF, 'h1FFFF, ones);
		r.req_type = code_t'(REQ_TOP);
		enqueue_req(r);
		r.req_type = code_t'(REQ_TOP - 1);
		enqueue_req(r);
		enqueue_req(make_req(bpvs_pkg::REQ_CLEAR, 'hFFFF, 'h1FFFF, ones));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// random traffic, generated close to the live length
		n = 0;
		while (n < RANDOM_ITEMS) begin
			while (req_backlog.size() >= 2)
				@(posedge clk);
			r = random_req();
			enqueue_req(r);
			if (r.req_type <= bpvs_pkg::REQ_READ)
				n++;
		end

		// every queued request answers once
		while (result_no < queued_no)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/bpvs_pkg.sv
hw/rtl/bpvs_ram.sv
hw/rtl/bpvs_datapath.sv
hw/rtl/bpvs_ctrl.sv
hw/rtl/bit_packed_vector_store.sv
dv/tb_bit_packed_vector_store.sv
